FILE: sv/wswf_pkg.sv
// Shared types and constants for the wall sensor window filter.
// Holds the sample and result beat layouts and the register index codes.
// No dependencies; compile this file first.
package wswf_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int SAMPLE_MAX  = 1023;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_WALL_THRESHOLD        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIDE_CLOSE_THRESHOLD  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRONT_CLOSE_THRESHOLD = 2'd2;

	localparam logic [SAMPLE_W-1:0] WALL_THRESHOLD_RESET        = 10'd300;
	localparam logic [SAMPLE_W-1:0] SIDE_CLOSE_THRESHOLD_RESET  = 10'd600;
	localparam logic [SAMPLE_W-1:0] FRONT_CLOSE_THRESHOLD_RESET = 10'd600;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t left_sample;
		sample_t right_sample;
		sample_t front_sample;
	} sample_item_t;

	typedef struct packed {
		sample_t left_mean;
		sample_t right_mean;
		sample_t front_mean;
		logic    left_wall;
		logic    right_wall;
		logic    front_wall;
		logic    left_close;
		logic    right_close;
		logic    front_close;
	} result_item_t;

endpackage

FILE: sv/wswf_stream_if.sv
// Valid/ready stream channel used for the sample and result beats.
// The payload type is a parameter; no other dependencies.
interface wswf_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/wswf_window.sv
// One sensor channel: a shift line of the last WINDOW_LENGTH samples and
// their running sum. Uses wswf_pkg for the sample width.
module wswf_window import wswf_pkg::*; #(
	parameter int WINDOW_LENGTH = 8,
	parameter int SUM_W         = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sample_t          sample,
	output logic [SUM_W-1:0] sum
);

	sample_t          taps_q [WINDOW_LENGTH];
	logic [SUM_W-1:0] sum_q;

	// The oldest sample falls off the end of the line as the new one enters,
	// so the sum never goes below zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) taps_q[i] <= '0;
			sum_q <= '0;
		end else if (push) begin
			taps_q[0] <= sample;
			for (int i = 1; i < WINDOW_LENGTH; i++) taps_q[i] <= taps_q[i-1];
			sum_q <= sum_q - SUM_W'(taps_q[WINDOW_LENGTH-1]) + SUM_W'(sample);
		end
	end

	assign sum = sum_q;

endmodule

FILE: sv/wswf_mean.sv
// Registered truncated mean: sum / WINDOW_LENGTH by reciprocal multiply.
// Uses wswf_pkg for the sample width.
module wswf_mean import wswf_pkg::*; #(
	parameter int WINDOW_LENGTH = 8,
	parameter int SUM_W         = 13
) (
	input  logic             clk,
	input  logic             load,
	input  logic [SUM_W-1:0] sum,
	output sample_t          mean
);

	// With SHIFT = SUM_W + ceil(log2(WINDOW_LENGTH)) and the rounded-up
	// reciprocal, the top bits of the product give the exact floor quotient
	// for every sum that fits in SUM_W bits.
	localparam int          LOG_W     = $clog2(WINDOW_LENGTH);
	localparam int          SHIFT     = SUM_W + LOG_W;
	localparam int          RECIP_W   = SHIFT + 1;
	localparam longint      RECIP_INT = ((64'd1 << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
	localparam int          PROD_W    = SUM_W + RECIP_W;

	logic [PROD_W-1:0] product;
	sample_t           mean_s2;

	assign product = PROD_W'(sum) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (load) mean_s2 <= product[SHIFT +: SAMPLE_W];
	end

	assign mean = mean_s2;

endmodule

FILE: sv/wall_sensor_window_filter.sv
// Wall sensor window filter: moving average of three sensors plus threshold flags.
// A result beat passes the running-sum, mean and output registers before it is offered.
// Throughput: one sample beat per cycle while the result output is not stalled; the
// stages are the running-sum update, the reciprocal multiply for the mean, and the
// threshold compare.
// Reset clears the windows, sums and pipeline valids; thresholds return to
// 300, 600 and 600.
module wall_sensor_window_filter import wswf_pkg::*; #(
	parameter int WINDOW_LENGTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	wswf_stream_if.sink            sample_in,
	wswf_stream_if.source          result_out
);

	localparam int SUM_W = $clog2(SAMPLE_MAX * WINDOW_LENGTH + 1);

	sample_t wall_threshold_q;
	sample_t side_close_threshold_q;
	sample_t front_close_threshold_q;

	logic         valid_s1;
	logic         valid_s2;
	logic         out_valid_q;
	result_item_t out_item_q;

	logic out_free;
	logic s2_free;
	logic adv_s1;
	logic adv_s2;
	logic accept;

	logic [SUM_W-1:0] left_sum;
	logic [SUM_W-1:0] right_sum;
	logic [SUM_W-1:0] front_sum;
	sample_t          left_mean;
	sample_t          right_mean;
	sample_t          front_mean;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_threshold_q        <= WALL_THRESHOLD_RESET;
			side_close_threshold_q  <= SIDE_CLOSE_THRESHOLD_RESET;
			front_close_threshold_q <= FRONT_CLOSE_THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WALL_THRESHOLD:        wall_threshold_q        <= cfg_data;
				REG_SIDE_CLOSE_THRESHOLD:  side_close_threshold_q  <= cfg_data;
				REG_FRONT_CLOSE_THRESHOLD: front_close_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage moves on when the one after it is empty or moving too.
	assign out_free        = !out_valid_q || result_out.ready;
	assign adv_s2          = valid_s2 && out_free;
	assign s2_free         = !valid_s2 || out_free;
	assign adv_s1          = valid_s1 && s2_free;
	assign sample_in.ready = !valid_s1 || s2_free;
	assign accept          = sample_in.valid && sample_in.ready;

	// The running sums are the first stage's payload: they change only on an
	// accepted beat, which happens only while that stage is empty or its sums move on.
	wswf_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_left_window (
		.clk(clk), .arst_n(arst_n), .push(accept),
		.sample(sample_in.data.left_sample), .sum(left_sum)
	);
	wswf_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_right_window (
		.clk(clk), .arst_n(arst_n), .push(accept),
		.sample(sample_in.data.right_sample), .sum(right_sum)
	);
	wswf_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_front_window (
		.clk(clk), .arst_n(arst_n), .push(accept),
		.sample(sample_in.data.front_sample), .sum(front_sum)
	);

	wswf_mean #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_left_mean (
		.clk(clk), .load(adv_s1), .sum(left_sum), .mean(left_mean)
	);
	wswf_mean #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_right_mean (
		.clk(clk), .load(adv_s1), .sum(right_sum), .mean(right_mean)
	);
	wswf_mean #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_front_mean (
		.clk(clk), .load(adv_s1), .sum(front_sum), .mean(front_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_in.ready) valid_s1 <= sample_in.valid;
			if (s2_free) valid_s2 <= valid_s1;
			if (out_free) out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_item_q.left_mean   <= left_mean;
			out_item_q.right_mean  <= right_mean;
			out_item_q.front_mean  <= front_mean;
			out_item_q.left_wall   <= left_mean > wall_threshold_q;
			out_item_q.right_wall  <= right_mean > wall_threshold_q;
			out_item_q.front_wall  <= front_mean > wall_threshold_q;
			out_item_q.left_close  <= left_mean > side_close_threshold_q;
			out_item_q.right_close <= right_mean > side_close_threshold_q;
			out_item_q.front_close <= front_mean > front_close_threshold_q;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_item_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat did not reach the first stage");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |-> !sample_in.ready)
		else $error("sample accepted while the first stage was blocked");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("beat lost between first and second stage");

	a_s2_moves_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> out_valid_q)
		else $error("beat lost between second stage and output register");

endmodule
